// ===== src/tsd_pkg.sv =====
// shared types and constants of the transport stream sync detector
// no dependencies; used by the controller, datapath, top level and bench by scoped names
package tsd_pkg;

  localparam int unsigned SKIP_W = 13;
  localparam int unsigned CONFIRM_W = 3;
  localparam int unsigned LIMIT_W = 13;
  localparam int unsigned MTS_PREFIX = 4;

  localparam logic [7:0] SYNC_BYTE = 8'h47;
  localparam logic [7:0] LEN_TS = 8'd188;
  localparam logic [7:0] LEN_MTS = 8'd192;
  localparam logic [7:0] LEN_RS = 8'd204;
  localparam logic [7:0] LEN_NONE = 8'd0;

  localparam logic [CONFIRM_W-1:0] CONFIRM_RST = 3'd3;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 13'd4096;

  // register indexes on the configuration port
  localparam logic REG_CONFIRM = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  typedef enum logic [2:0] {
    KIND_TS = 3'd0,
    KIND_MTS = 3'd1,
    KIND_RS = 3'd2,
    KIND_BIN = 3'd3,
    KIND_OOD = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    SP_TS = 2'd0,
    SP_MTS = 2'd1,
    SP_RS = 2'd2
  } sp_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        stream_kind;
    logic [7:0]        packet_length;
    logic [SKIP_W-1:0] skip_bytes;
  } out_item_t;

  typedef struct packed {
    logic  wr_en;
    logic  off_clr;
    logic  off_inc;
    logic  rd_off;
    logic  rd_pos;
    logic  chain_start;
    logic  chain_next;
    sp_t   sp;
    logic  res_set;
    kind_t res_kind;
    logic  out_load;
  } tsd_cmd_t;

  typedef struct packed {
    logic byte_sync;
    logic off_oob;
    logic pos_oob;
    logic off_over;
    logic off_ge4;
    logic cnt_lock;
    sp_t  sp;
    logic out_free;
  } tsd_stat_t;

  function automatic logic [7:0] spacing(input sp_t sp);
    logic [7:0] r;
    case (sp)
      SP_TS: r = LEN_TS;
      SP_MTS: r = LEN_MTS;
      SP_RS: r = LEN_RS;
      default: r = LEN_RS;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] kind_len(input kind_t k);
    logic [7:0] r;
    case (k)
      KIND_TS: r = LEN_TS;
      KIND_MTS: r = LEN_MTS;
      KIND_RS: r = LEN_RS;
      default: r = LEN_NONE;
    endcase
    return r;
  endfunction

endpackage

// ===== src/tsd_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module tsd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/tsd_ctrl.sv =====
// controller of the sync detector: load, offset scan and chain follow sequencing
// depends on tsd_pkg
module tsd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_last,
  output logic                 in_stall,
  input  tsd_pkg::tsd_stat_t   stat,
  output tsd_pkg::tsd_cmd_t    cmd
);

  typedef enum logic [5:0] {
    ST_LOAD   = 6'b000001,
    ST_OFF_RD = 6'b000010,
    ST_OFF_CK = 6'b000100,
    ST_CH_RD  = 6'b001000,
    ST_CH_CK  = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_stall = 1'b1;
    cmd.wr_en = 1'b0;
    cmd.off_clr = 1'b0;
    cmd.off_inc = 1'b0;
    cmd.rd_off = 1'b0;
    cmd.rd_pos = 1'b0;
    cmd.chain_start = 1'b0;
    cmd.chain_next = 1'b0;
    cmd.sp = tsd_pkg::SP_TS;
    cmd.res_set = 1'b0;
    cmd.res_kind = tsd_pkg::KIND_OOD;
    cmd.out_load = 1'b0;
    case (state_r)
      ST_LOAD: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.wr_en = 1'b1;
          if (in_last) begin
            cmd.off_clr = 1'b1;
            state_nxt = ST_OFF_RD;
          end
        end
      end
      ST_OFF_RD: begin
        if (stat.off_oob) begin
          cmd.res_set = 1'b1;
          cmd.res_kind = tsd_pkg::KIND_OOD;
          state_nxt = ST_DONE;
        end else begin
          cmd.rd_off = 1'b1;
          state_nxt = ST_OFF_CK;
        end
      end
      ST_OFF_CK: begin
        if (!stat.byte_sync) begin
          cmd.off_inc = 1'b1;
          if (stat.off_over) begin
            cmd.res_set = 1'b1;
            cmd.res_kind = tsd_pkg::KIND_BIN;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_OFF_RD;
          end
        end else begin
          cmd.chain_start = 1'b1;
          cmd.sp = tsd_pkg::SP_TS;
          state_nxt = ST_CH_RD;
        end
      end
      ST_CH_RD: begin
        if (stat.pos_oob) begin
          cmd.res_set = 1'b1;
          cmd.res_kind = tsd_pkg::KIND_OOD;
          state_nxt = ST_DONE;
        end else begin
          cmd.rd_pos = 1'b1;
          state_nxt = ST_CH_CK;
        end
      end
      ST_CH_CK: begin
        if (stat.byte_sync && !stat.cnt_lock) begin
          cmd.chain_next = 1'b1;
          state_nxt = ST_CH_RD;
        end else begin
          // chain ended: locked or broken, decided per spacing
          case (stat.sp)
            tsd_pkg::SP_TS: begin
              if (stat.byte_sync) begin
                cmd.res_set = 1'b1;
                cmd.res_kind = tsd_pkg::KIND_TS;
                state_nxt = ST_DONE;
              end else begin
                cmd.chain_start = 1'b1;
                cmd.sp = tsd_pkg::SP_MTS;
                state_nxt = ST_CH_RD;
              end
            end
            tsd_pkg::SP_MTS: begin
              // mts lock too close to the start falls through to the 204 test
              if (stat.byte_sync && stat.off_ge4) begin
                cmd.res_set = 1'b1;
                cmd.res_kind = tsd_pkg::KIND_MTS;
                state_nxt = ST_DONE;
              end else begin
                cmd.chain_start = 1'b1;
                cmd.sp = tsd_pkg::SP_RS;
                state_nxt = ST_CH_RD;
              end
            end
            default: begin
              if (stat.byte_sync) begin
                cmd.res_set = 1'b1;
                cmd.res_kind = tsd_pkg::KIND_RS;
                state_nxt = ST_DONE;
              end else begin
                cmd.off_inc = 1'b1;
                state_nxt = ST_OFF_RD;
              end
            end
          endcase
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

endmodule

// ===== src/tsd_dp.sv =====
// datapath of the sync detector: window ram, fill count, offset and chain
// counters, result and output registers; depends on tsd_pkg and tsd_ram
module tsd_dp #(
  parameter int unsigned WINDOW_BYTES = 8192
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tsd_pkg::in_item_t                 in_data,
  input  logic [tsd_pkg::CONFIRM_W-1:0]     sync_confirm,
  input  logic [tsd_pkg::LIMIT_W-1:0]       search_limit,
  input  tsd_pkg::tsd_cmd_t                 cmd,
  output tsd_pkg::tsd_stat_t                stat,
  input  logic                              out_stall,
  output logic                              out_valid,
  output tsd_pkg::out_item_t                out_data
);

  localparam int unsigned ADDR_W = $clog2(WINDOW_BYTES);
  localparam int unsigned FILL_W = $clog2(WINDOW_BYTES + 1);
  localparam int unsigned POS_W = FILL_W + 1;
  localparam int unsigned CMP_W = (FILL_W + 1 > 14) ? FILL_W + 1 : 14;
  localparam int unsigned CONFIRM_W_EXT = tsd_pkg::CONFIRM_W + 1;

  logic [FILL_W-1:0]             fill_r, fill_nxt;
  logic [FILL_W-1:0]             off_r, off_nxt;
  logic [POS_W-1:0]              pos_r, pos_nxt;
  logic [tsd_pkg::CONFIRM_W-1:0] cnt_r, cnt_nxt;
  tsd_pkg::sp_t                  sp_r, sp_nxt;
  tsd_pkg::kind_t                kind_r, kind_nxt;
  logic                          out_valid_r, out_valid_nxt;
  tsd_pkg::out_item_t            out_item_r, out_item_nxt;

  logic                          fill_full;
  logic                          ram_we;
  logic                          ram_re;
  logic [ADDR_W-1:0]             ram_raddr;
  logic [7:0]                    ram_rdata;
  logic [CMP_W-1:0]              off_ext;
  logic [CMP_W-1:0]              off_mts;
  logic [CONFIRM_W_EXT-1:0]      cnt_inc;

  assign fill_full = (fill_r == FILL_W'(WINDOW_BYTES));
  assign ram_we = cmd.wr_en && !fill_full;
  assign ram_re = cmd.rd_off || cmd.rd_pos;
  assign ram_raddr = cmd.rd_pos ? pos_r[ADDR_W-1:0] : off_r[ADDR_W-1:0];

  tsd_ram #(
    .WIDTH(8),
    .DEPTH(WINDOW_BYTES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(fill_r[ADDR_W-1:0]),
    .wdata(in_data.data_byte),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign off_ext = CMP_W'(off_r);
  assign off_mts = off_ext - CMP_W'(tsd_pkg::MTS_PREFIX);
  assign cnt_inc = CONFIRM_W_EXT'(cnt_r) + CONFIRM_W_EXT'(1);

  always_comb begin
    stat.byte_sync = (ram_rdata == tsd_pkg::SYNC_BYTE);
    stat.off_oob = (off_r >= fill_r);
    stat.pos_oob = (pos_r >= POS_W'(fill_r));
    stat.off_over = ((off_ext + CMP_W'(1)) > CMP_W'(search_limit));
    stat.off_ge4 = (off_ext >= CMP_W'(tsd_pkg::MTS_PREFIX));
    stat.cnt_lock = (cnt_inc >= CONFIRM_W_EXT'(sync_confirm));
    stat.sp = sp_r;
    stat.out_free = !out_valid_r || !out_stall;
  end

  always_comb begin
    fill_nxt = fill_r;
    off_nxt = off_r;
    pos_nxt = pos_r;
    cnt_nxt = cnt_r;
    sp_nxt = sp_r;
    kind_nxt = kind_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt = out_item_r;
    if (ram_we) begin
      fill_nxt = fill_r + FILL_W'(1);
    end
    if (cmd.off_clr) begin
      off_nxt = '0;
    end else if (cmd.off_inc) begin
      off_nxt = off_r + FILL_W'(1);
    end
    if (cmd.chain_start) begin
      pos_nxt = POS_W'(off_r) + POS_W'(tsd_pkg::spacing(cmd.sp));
      cnt_nxt = tsd_pkg::CONFIRM_W'(1);
      sp_nxt = cmd.sp;
    end else if (cmd.chain_next) begin
      pos_nxt = pos_r + POS_W'(tsd_pkg::spacing(sp_r));
      cnt_nxt = cnt_inc[tsd_pkg::CONFIRM_W-1:0];
    end
    if (cmd.res_set) begin
      kind_nxt = cmd.res_kind;
    end
    if (cmd.out_load) begin
      fill_nxt = '0;
      out_valid_nxt = 1'b1;
      out_item_nxt.stream_kind = kind_r;
      out_item_nxt.packet_length = tsd_pkg::kind_len(kind_r);
      case (kind_r)
        tsd_pkg::KIND_TS, tsd_pkg::KIND_RS: begin
          out_item_nxt.skip_bytes = off_ext[tsd_pkg::SKIP_W-1:0];
        end
        tsd_pkg::KIND_MTS: begin
          out_item_nxt.skip_bytes = off_mts[tsd_pkg::SKIP_W-1:0];
        end
        default: begin
          out_item_nxt.skip_bytes = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    off_r <= off_nxt;
    pos_r <= pos_nxt;
    cnt_r <= cnt_nxt;
    sp_r <= sp_nxt;
    kind_r <= kind_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_item_r;

endmodule

// ===== src/ts_sync_packet_size_detector_core.sv =====
// top level of the transport stream sync and packet size detector
// depends on tsd_pkg, tsd_ctrl, tsd_dp (and through it tsd_ram)
//
// usage:
//  - in channel (in_valid / in_stall / in_data): one raw byte per item, one
//    item per cycle while loading; the item with last set closes the window
//  - bytes beyond WINDOW_BYTES in one window are dropped, last still counts
//  - after last the block stalls the input and scans the window ram: each
//    offset test and each sync byte followed along a chain is one ram read
//    state plus one compare state; the scan length is set by the single read
//    port of the window ram and by the data itself
//  - the search then yields exactly one out item: stream_kind, packet_length
//    and skip_bytes; it sits in an output register until taken, and loading
//    of the next window resumes right away
//  - if out_stall holds a previous item when a new search ends, the block
//    waits in its done state until the output register frees up
//  - config (sync_confirm at 0x0, search_limit at 0x4) is to be written over the
//    apb-style port only while the block is idle; the block does not enforce it
//  - reset: fill count cleared, output empty, sync_confirm = 3,
//    search_limit = 4096; the window ram needs no clearing pass
module ts_sync_packet_size_detector_core #(
  parameter int unsigned WINDOW_BYTES = 8192
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tsd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tsd_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [tsd_pkg::CONFIRM_W-1:0] sync_confirm_r, sync_confirm_nxt;
  logic [tsd_pkg::LIMIT_W-1:0]   search_limit_r, search_limit_nxt;
  logic                          cfg_wr;
  tsd_pkg::tsd_cmd_t             cmd;
  tsd_pkg::tsd_stat_t            stat;

  // config registers, index taken from the word address bit
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    sync_confirm_nxt = sync_confirm_r;
    search_limit_nxt = search_limit_r;
    if (cfg_wr) begin
      case (paddr[2])
        tsd_pkg::REG_CONFIRM: sync_confirm_nxt = pwdata[tsd_pkg::CONFIRM_W-1:0];
        tsd_pkg::REG_LIMIT: search_limit_nxt = pwdata[tsd_pkg::LIMIT_W-1:0];
        default: sync_confirm_nxt = sync_confirm_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_confirm_r <= tsd_pkg::CONFIRM_RST;
      search_limit_r <= tsd_pkg::LIMIT_RST;
    end else begin
      sync_confirm_r <= sync_confirm_nxt;
      search_limit_r <= search_limit_nxt;
    end
  end

  always_comb begin
    case (paddr[2])
      tsd_pkg::REG_CONFIRM: prdata = 32'(sync_confirm_r);
      tsd_pkg::REG_LIMIT: prdata = 32'(search_limit_r);
      default: prdata = '0;
    endcase
  end

  // sequencing
  tsd_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_last (in_data.last),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  // window storage, scan counters and output register
  tsd_dp #(
    .WINDOW_BYTES(WINDOW_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .sync_confirm(sync_confirm_r),
    .search_limit(search_limit_r),
    .cmd         (cmd),
    .stat        (stat),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_data    (out_data)
  );

  // a result never overwrites an item still waiting at the output
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result loaded over a pending out item");

  // a loaded result is offered on the next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid)
    else $error("loaded result not presented");

  // ram writes only come from accepted in items
  a_wr_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> (in_valid && !in_stall))
    else $error("window write without accepted item");

  // chain reads stay inside the loaded window
  a_rd_inside: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_pos |-> !stat.pos_oob)
    else $error("chain read past loaded data");

endmodule

// ===== bench/ts_sync_packet_size_detector_core_tb.sv =====
// self-checking bench for ts_sync_packet_size_detector_core: short probe table, typed-in
// verdicts, then random windows of ts/mts/rs packet trains, broken trains and noise checked
// against an in-bench sync search model; depends on tsd_pkg and the core only
`timescale 1ns / 100ps

module ts_sync_packet_size_detector_core_tb;

  localparam int unsigned WIN_BYTES = 8192;
  localparam int unsigned MAX_CYCLES = 2_000_000;
  localparam int unsigned GUARD_CYCLES = 8;        // settle time before a register write
  localparam int unsigned END_CYCLES = 200;        // watch for stray results at the end
  localparam int unsigned HOLD_CYCLES = 2000;      // long receiver hold-off
  localparam int unsigned RAND_ITEMS = 1550;       // total items of the run
  localparam int unsigned TAIL_ITEMS = 300;        // items of the final full-rate stretch
  localparam int unsigned LEAD_CAP = 40;           // most bytes ahead of the first sync, at search limits of 40 and up
  localparam int unsigned N_PROBES = 17;

  // outcome of following sync bytes at one spacing
  typedef enum logic [1:0] {
    TRAIL_MISS,
    TRAIL_LOCK,
    TRAIL_END
  } trail_t;

  // one probe: register setting it needs, the byte, and an optional typed-in verdict
  typedef struct packed {
    logic [tsd_pkg::CONFIRM_W-1:0] confirm;
    logic [tsd_pkg::LIMIT_W-1:0]   limit;
    logic [7:0]                    data_byte;
    logic                          last;
    logic                          typed;
    tsd_pkg::out_item_t            res;
  } probe_t;

  localparam tsd_pkg::out_item_t RES_OOD = '{tsd_pkg::KIND_OOD, tsd_pkg::LEN_NONE, '0};
  localparam tsd_pkg::out_item_t RES_BIN = '{tsd_pkg::KIND_BIN, tsd_pkg::LEN_NONE, '0};
  localparam tsd_pkg::out_item_t RES_NONE = '0;

  // directed probes; each window is one to three bytes so the verdict is obvious
  localparam probe_t PROBES [0:N_PROBES-1] = '{
    // reset setting: lone sync byte runs off the end, lone zero runs off the end
    '{3'd3, 13'd4096, 8'h47, 1'b1, 1'b1, RES_OOD},
    '{3'd3, 13'd4096, 8'h00, 1'b1, 1'b1, RES_OOD},
    // sync byte after a non-sync one, chain runs out of data
    '{3'd3, 13'd4096, 8'hff, 1'b0, 1'b0, RES_NONE},
    '{3'd3, 13'd4096, 8'h47, 1'b0, 1'b0, RES_NONE},
    '{3'd3, 13'd4096, 8'haa, 1'b1, 1'b1, RES_OOD},
    // zero search limit: first non-sync byte makes it binary
    '{3'd3, 13'd0, 8'hff, 1'b1, 1'b1, RES_BIN},
    '{3'd3, 13'd0, 8'h00, 1'b0, 1'b0, RES_NONE},
    '{3'd3, 13'd0, 8'h47, 1'b1, 1'b1, RES_BIN},
    '{3'd3, 13'd0, 8'h47, 1'b1, 1'b1, RES_OOD},
    // limit 1: one non-sync offset tolerated, the second one is binary
    '{3'd7, 13'd1, 8'h55, 1'b1, 1'b1, RES_OOD},
    '{3'd7, 13'd1, 8'h55, 1'b0, 1'b0, RES_NONE},
    '{3'd7, 13'd1, 8'h12, 1'b1, 1'b1, RES_BIN},
    '{3'd7, 13'd1, 8'h47, 1'b0, 1'b0, RES_NONE},
    '{3'd7, 13'd1, 8'hff, 1'b1, 1'b1, RES_OOD},
    // confirm 1, no sync at all in a short window
    '{3'd1, 13'd4096, 8'h80, 1'b0, 1'b0, RES_NONE},
    '{3'd1, 13'd4096, 8'h7f, 1'b0, 1'b0, RES_NONE},
    '{3'd1, 13'd4096, 8'h01, 1'b1, 1'b1, RES_OOD}
  };

  // clock, reset and block ports; every input known from time zero
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  tsd_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  tsd_pkg::out_item_t out_data;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  // model of the block: loaded window and register copies
  logic [7:0]                    model_win [0:WIN_BYTES-1];
  int unsigned                   model_fill = 0;
  logic [tsd_pkg::CONFIRM_W-1:0] cfg_confirm = tsd_pkg::CONFIRM_RST;
  logic [tsd_pkg::LIMIT_W-1:0]   cfg_limit = tsd_pkg::LIMIT_RST;

  // verdicts predicted for windows already closed, oldest first
  tsd_pkg::out_item_t verdict_q [$];
  // bytes of the window being built
  logic [7:0] pend_q [$];

  // shared control between stimulus and receiver
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned burst_left = 0;

  // run statistics
  int unsigned cycle_cnt = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned err_cnt = 0;
  int unsigned cfg_phases = 0;
  int unsigned kind_seen [0:4] = '{0, 0, 0, 0, 0};

  ts_sync_packet_size_detector_core #(
    .WINDOW_BYTES(WIN_BYTES)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == MAX_CYCLES) begin
      $display("tb: no progress, stopped after %0d cycles", cycle_cnt);
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sync search model
  // ---------------------------------------------------------------------------

  // follow sync bytes from start at one spacing; the start byte counts as the first
  function automatic trail_t follow_syncs(input int unsigned start, input int unsigned spacing);
    int unsigned pos;
    int unsigned hits;
    trail_t      r;
    bit          done;
    pos = start;
    hits = 1;
    r = TRAIL_MISS;
    done = 1'b0;
    while (!done) begin
      pos += spacing;
      if (pos >= model_fill) begin
        // reads stop at the fill count, which never exceeds the window size
        r = TRAIL_END;
        done = 1'b1;
      end else if (model_win[pos] != tsd_pkg::SYNC_BYTE) begin
        r = TRAIL_MISS;
        done = 1'b1;
      end else begin
        hits++;
        // only checked after a second sync, so confirm 1 and 2 behave alike
        if (hits >= cfg_confirm) begin
          r = TRAIL_LOCK;
          done = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // search the loaded window: first offset whose sync repeats at 188, 192 or 204, else binary or out of data
  function automatic tsd_pkg::out_item_t detect_sync();
    tsd_pkg::out_item_t res;
    int unsigned        off;
    trail_t             t;
    bit                 done;
    res = RES_OOD;
    off = 0;
    done = 1'b0;
    while (!done) begin
      if (off >= model_fill) begin
        done = 1'b1;
      end else if (model_win[off] != tsd_pkg::SYNC_BYTE) begin
        off++;
        if (off > cfg_limit) begin
          res = RES_BIN;
          done = 1'b1;
        end
      end else begin
        t = follow_syncs(off, tsd_pkg::LEN_TS);
        if (t == TRAIL_END) begin
          done = 1'b1;
        end else if (t == TRAIL_LOCK) begin
          res = '{tsd_pkg::KIND_TS, tsd_pkg::LEN_TS, tsd_pkg::SKIP_W'(off)};
          done = 1'b1;
        end else begin
          t = follow_syncs(off, tsd_pkg::LEN_MTS);
          if (t == TRAIL_END) begin
            done = 1'b1;
          end else if (t == TRAIL_LOCK && off >= tsd_pkg::MTS_PREFIX) begin
            // skip reported up to the timestamp prefix
            res = '{tsd_pkg::KIND_MTS, tsd_pkg::LEN_MTS,
                    tsd_pkg::SKIP_W'(off - tsd_pkg::MTS_PREFIX)};
            done = 1'b1;
          end else begin
            // mts lock too close to the start falls through to the rs test
            t = follow_syncs(off, tsd_pkg::LEN_RS);
            if (t == TRAIL_END) begin
              done = 1'b1;
            end else if (t == TRAIL_LOCK) begin
              res = '{tsd_pkg::KIND_RS, tsd_pkg::LEN_RS, tsd_pkg::SKIP_W'(off)};
              done = 1'b1;
            end else begin
              off++;
            end
          end
        end
      end
    end
    return res;
  endfunction

  // one accepted byte; returns 1 with the verdict when it closes the window
  function automatic bit load_byte(input tsd_pkg::in_item_t it,
                                   output tsd_pkg::out_item_t res);
    // a full window drops the byte, but last still starts the search
    if (model_fill < WIN_BYTES) begin
      model_win[model_fill] = it.data_byte;
      model_fill++;
    end
    if (!it.last) return 1'b0;
    res = detect_sync();
    model_fill = 0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: stall pattern and checking
  // ---------------------------------------------------------------------------

  task automatic flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("tb: error at cycle %0d: %s", cycle_cnt, msg);
  endtask

  // random stall bursts while idling is on, plus one long hold-off when asked
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (idle_on && burst_left != 0) begin
      burst_left--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      burst_left = $urandom_range(0, 15);
      out_stall <= 1'b1;
    end else begin
      burst_left = 0;
      out_stall <= 1'b0;
    end
  end

  // compare each taken result with the oldest predicted verdict
  always @(posedge clk) begin : result_check
    tsd_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (verdict_q.size() == 0) begin
        flag_error($sformatf("unexpected result kind %0d len %0d skip %0d",
                             out_data.stream_kind, out_data.packet_length,
                             out_data.skip_bytes));
      end else begin
        want = verdict_q.pop_front();
        if (want.stream_kind <= tsd_pkg::KIND_OOD) kind_seen[want.stream_kind]++;
        if (out_data.stream_kind !== want.stream_kind)
          flag_error($sformatf("stream_kind exp %0d got %0d", want.stream_kind,
                               out_data.stream_kind));
        if (out_data.packet_length !== want.packet_length)
          flag_error($sformatf("packet_length exp %0d got %0d", want.packet_length,
                               out_data.packet_length));
        if (out_data.skip_bytes !== want.skip_bytes)
          flag_error($sformatf("skip_bytes exp %0d got %0d", want.skip_bytes,
                               out_data.skip_bytes));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // offer one byte until taken; typed verdicts replace the model's where given
  task automatic push_byte(input logic [7:0] b, input logic fin, input logic typed,
                           input tsd_pkg::out_item_t typed_res);
    tsd_pkg::in_item_t  it;
    tsd_pkg::out_item_t res;
    it.data_byte = b;
    it.last = fin;
    if (idle_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (load_byte(it, res)) verdict_q.push_back(typed ? typed_res : res);
  endtask

  // send the built window, last set on its final byte
  task automatic send_window();
    for (int i = 0; i < pend_q.size(); i++)
      push_byte(pend_q[i], i == pend_q.size() - 1, 1'b0, RES_NONE);
    pend_q.delete();
  endtask

  // stop offering and wait until every verdict has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (GUARD_CYCLES) @(posedge clk);
  endtask

  // apb write: setup cycle, access cycle, then idle before the next
  task automatic write_reg(input logic idx, input logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == tsd_pkg::REG_CONFIRM) cfg_confirm = val[tsd_pkg::CONFIRM_W-1:0];
    else cfg_limit = val[tsd_pkg::LIMIT_W-1:0];
    @(posedge clk);
  endtask

  task automatic apply_cfg(input int unsigned confirm, input int unsigned limit);
    settle();
    write_reg(tsd_pkg::REG_CONFIRM, confirm);
    write_reg(tsd_pkg::REG_LIMIT, limit);
    cfg_phases++;
  endtask

  // any byte but the sync byte
  function automatic logic [7:0] filler();
    logic [7:0] b;
    b = $urandom_range(0, 255);
    if (b == tsd_pkg::SYNC_BYTE) b = 8'h00;
    return b;
  endfunction

  // lead bytes, then nsync sync bytes at the spacing with random payload, then a tail
  function automatic void add_train(input int unsigned lead, input int unsigned spacing,
                                    input int unsigned nsync, input int unsigned tail,
                                    input bit clean_lead);
    for (int i = 0; i < lead; i++)
      pend_q.push_back(clean_lead ? filler() : 8'($urandom_range(0, 255)));
    for (int s = 0; s < nsync; s++) begin
      pend_q.push_back(tsd_pkg::SYNC_BYTE);
      if (s != nsync - 1)
        for (int k = 1; k < spacing; k++) pend_q.push_back(8'($urandom_range(0, 255)));
    end
    for (int i = 0; i < tail; i++) pend_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  // short window rich in sync bytes
  function automatic void add_noise(input int unsigned max_len);
    repeat ($urandom_range(1, max_len))
      pend_q.push_back(($urandom_range(0, 3) == 0) ? tsd_pkg::SYNC_BYTE
                                                   : 8'($urandom_range(0, 255)));
  endfunction

  // one random window: mostly well-formed trains, some broken, some noise
  task automatic random_window();
    int unsigned pick;
    int unsigned spacing;
    int unsigned first;
    int unsigned nsync;
    int unsigned cap;
    pick = $urandom_range(0, 99);
    // keep the packet start short and mostly within the search limit
    cap = (cfg_limit < LEAD_CAP) ? cfg_limit + 2 : LEAD_CAP;
    first = $urandom_range(0, cap);
    nsync = (cfg_confirm < 2) ? 2 : cfg_confirm;
    // now and then one sync short of a lock
    if ($urandom_range(0, 5) == 0) nsync--;
    if (pick < 85) begin
      if (pick < 25) spacing = tsd_pkg::LEN_TS;
      else if (pick < 50) spacing = tsd_pkg::LEN_MTS;
      else if (pick < 70) spacing = tsd_pkg::LEN_RS;
      else begin
        case ($urandom_range(0, 2))
          0: spacing = tsd_pkg::LEN_TS;
          1: spacing = tsd_pkg::LEN_MTS;
          default: spacing = tsd_pkg::LEN_RS;
        endcase
      end
      // mts start inside the timestamp prefix
      if (spacing == tsd_pkg::LEN_MTS && $urandom_range(0, 3) == 0)
        first = $urandom_range(0, 3);
      add_train(first, spacing, nsync, $urandom_range(0, 8), 1'b0);
      // broken train: one later sync byte knocked out
      if (pick >= 70 && nsync >= 2)
        pend_q[first + spacing * $urandom_range(1, nsync - 1)] = filler();
    end else begin
      add_noise(48);
    end
    send_window();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned phase;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // probe table, registers rewritten whenever a probe needs another setting
    for (int r = 0; r < N_PROBES; r++) begin
      if (PROBES[r].confirm != cfg_confirm || PROBES[r].limit != cfg_limit)
        apply_cfg(PROBES[r].confirm, PROBES[r].limit);
      push_byte(PROBES[r].data_byte, PROBES[r].last, PROBES[r].typed, PROBES[r].res);
    end
    settle();

    // random phases, each at its own register setting
    phase = 0;
    while (items_sent < RAND_ITEMS - TAIL_ITEMS) begin
      // every third phase runs without any idling
      idle_on = (phase % 3 != 1);
      case (phase)
        0: apply_cfg(1, 4096);
        1: apply_cfg(2, 50);
        2: apply_cfg(2, 0);
        3: apply_cfg(3, 4096);
        4: apply_cfg(1, 1);
        default: begin
          if ($urandom_range(0, 3) == 0)
            apply_cfg($urandom_range(1, 3), ($urandom_range(0, 1) != 0) ? 4096 : 0);
          else
            apply_cfg($urandom_range(1, 3), $urandom_range(0, 4096));
        end
      endcase
      if (phase == 1) begin
        // receiver holds off while tiny windows keep coming: output fills, input stalls
        hold_req = 1'b1;
        repeat (30) begin
          add_noise(12);
          send_window();
        end
      end else begin
        for (int w = 0; w < 2 && items_sent < RAND_ITEMS - TAIL_ITEMS; w++)
          random_window();
      end
      phase++;
    end

    // last stretch at full rate on both sides
    idle_on = 1'b0;
    apply_cfg($urandom_range(1, 2), $urandom_range(0, 4096));
    while (items_sent < RAND_ITEMS) random_window();
    settle();
    repeat (END_CYCLES) @(posedge clk);

    $display("tb: %0d items in %0d register settings, %0d results checked",
             items_sent, cfg_phases, results_seen);
    $display("tb: ts %0d, mts %0d, rs %0d, binary %0d, out of data %0d, %0d errors",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4], err_cnt);
    if (err_cnt == 0 && verdict_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
